// ----- design/tga_rle_pkg.sv -----
// Shared types and constants for the TGA run-length pixel decoder.
`timescale 1ns / 1ps

package tga_rle_pkg;

  // Depth of the queue between the byte parser and the output stage.
  localparam int QUEUE_DEPTH = 2;

  // Packet header coding: below the base is a raw packet, else a run.
  localparam logic [7:0] HDR_RUN_BASE = 8'd128;
  localparam logic [7:0] RUN_OFFSET   = 8'd127;

  // Pixel size codes of the bytes_per_pixel register, and the image_pixels reset value.
  localparam logic [2:0] BPP_WIDE   = 3'd4;
  localparam logic [2:0] BPP_RESET  = 3'd3;
  localparam logic [31:0] IMG_RESET = 32'd1;

  // Configuration register indexes.
  typedef enum logic [1:0] {
    CFG_BYTES_PER_PIXEL = 2'd0,
    CFG_IMAGE_PIXELS    = 2'd1
  } cfg_idx_t;

  // One decoded pixel or run as it travels from parser to output stage.
  typedef struct packed {
    logic [3:0][7:0] bytes;   // stored pixel bytes in B, G, R, A order
    logic            wide;    // pixel was four bytes at completion
    logic [7:0]      count;   // repeat count
    logic            last;    // completes the image
    logic            clamped; // run cut to the remaining pixels
  } px_entry_t;

endpackage

// ----- design/tga_rle_front.sv -----
// Byte parser: packet headers, pixel assembly and pixel accounting.
`timescale 1ns / 1ps

module tga_rle_front (
  input  logic                   clk,
  input  logic                   rst,
  // Compressed byte stream
  input  logic                   s_tvalid,
  output logic                   s_tready,
  input  logic [7:0]             s_tdata,   // data_byte
  input  logic                   s_tuser,   // frame_start
  // Configuration writes
  input  logic                   cfg_valid,
  input  logic [1:0]             cfg_index,
  input  logic [31:0]            cfg_data,
  // Queue write side
  input  logic                   q_full,
  output logic                   q_push,
  output tga_rle_pkg::px_entry_t q_data
);

  logic [2:0]      bytes_per_pixel;
  logic [31:0]     image_pixels;

  logic            expect_header;
  logic            run_packet;
  logic [7:0]      packet_left;
  logic [1:0]      byte_in_pixel;
  logic [3:0][7:0] pixel_bytes;
  logic [31:0]     pixels_left;

  logic            expect_header_next;
  logic            run_packet_next;
  logic [7:0]      packet_left_next;
  logic [1:0]      byte_in_pixel_next;
  logic [3:0][7:0] pixel_bytes_next;
  logic [31:0]     pixels_left_next;

  logic            accept;
  logic            emit;
  logic            wide;
  logic [2:0]      size;
  logic [2:0]      bip_inc;
  logic [3:0][7:0] merged;
  logic            clamp;
  logic [7:0]      count;

  assign s_tready = !q_full;
  assign accept   = s_tvalid && s_tready;
  assign wide     = (bytes_per_pixel == tga_rle_pkg::BPP_WIDE);
  assign size     = wide ? 3'd4 : 3'd3;

  // Next decode state for the byte on the input.
  always_comb begin
    // A frame start resets packet tracking before the byte is looked at.
    pixels_left_next   = s_tuser ? image_pixels : pixels_left;
    expect_header_next = s_tuser ? 1'b1 : expect_header;
    run_packet_next    = s_tuser ? 1'b0 : run_packet;
    packet_left_next   = s_tuser ? 8'd0 : packet_left;
    byte_in_pixel_next = s_tuser ? 2'd0 : byte_in_pixel;
    pixel_bytes_next   = pixel_bytes;
    emit               = 1'b0;
    clamp              = 1'b0;
    count              = 8'd1;

    bip_inc = {1'b0, byte_in_pixel_next} + 3'd1;
    for (int i = 0; i < 4; i++) begin
      merged[i] = (byte_in_pixel_next == 2'(i)) ? s_tdata : pixel_bytes[i];
    end

    if (pixels_left_next == 32'd0) begin
      // No image in progress: the byte is dropped.
    end else if (expect_header_next) begin
      if (s_tdata < tga_rle_pkg::HDR_RUN_BASE) begin
        run_packet_next  = 1'b0;
        packet_left_next = s_tdata + 8'd1;
      end else begin
        run_packet_next  = 1'b1;
        packet_left_next = s_tdata - tga_rle_pkg::RUN_OFFSET;
      end
      expect_header_next = 1'b0;
      byte_in_pixel_next = 2'd0;
    end else begin
      pixel_bytes_next = merged;
      if (bip_inc < size) begin
        byte_in_pixel_next = bip_inc[1:0];
      end else begin
        // Pixel complete: one result for it.
        byte_in_pixel_next = 2'd0;
        emit               = 1'b1;
        if (run_packet_next) begin
          clamp            = ({24'd0, packet_left_next} > pixels_left_next);
          count            = clamp ? pixels_left_next[7:0] : packet_left_next;
          packet_left_next = 8'd0;
        end else begin
          packet_left_next = packet_left_next - 8'd1;
        end
        pixels_left_next = pixels_left_next - {24'd0, count};
        if (packet_left_next == 8'd0) begin
          expect_header_next = 1'b1;
        end
      end
    end
  end

  assign q_push         = accept && emit;
  assign q_data.bytes   = merged;
  assign q_data.wide    = wide;
  assign q_data.count   = count;
  assign q_data.last    = (pixels_left_next == 32'd0);
  assign q_data.clamped = clamp;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      bytes_per_pixel <= tga_rle_pkg::BPP_RESET;
      image_pixels    <= tga_rle_pkg::IMG_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        tga_rle_pkg::CFG_BYTES_PER_PIXEL: bytes_per_pixel <= cfg_data[2:0];
        tga_rle_pkg::CFG_IMAGE_PIXELS:    image_pixels    <= cfg_data;
        default: ;
      endcase
    end
  end

  // Decode state advances on every accepted byte.
  always_ff @(posedge clk) begin
    if (rst) begin
      expect_header <= 1'b1;
      run_packet    <= 1'b0;
      packet_left   <= 8'd0;
      byte_in_pixel <= 2'd0;
      pixel_bytes   <= '0;
      pixels_left   <= 32'd0;
    end else if (accept) begin
      expect_header <= expect_header_next;
      run_packet    <= run_packet_next;
      packet_left   <= packet_left_next;
      byte_in_pixel <= byte_in_pixel_next;
      pixel_bytes   <= pixel_bytes_next;
      pixels_left   <= pixels_left_next;
    end
  end

endmodule

// ----- design/tga_rle_queue.sv -----
// Small queue of decoded pixels between the parser and the output stage.
`timescale 1ns / 1ps

module tga_rle_queue #(
  parameter int DEPTH = tga_rle_pkg::QUEUE_DEPTH
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   push,
  input  tga_rle_pkg::px_entry_t push_data,
  output logic                   full,
  input  logic                   pop,
  output tga_rle_pkg::px_entry_t pop_data,
  output logic                   empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  tga_rle_pkg::px_entry_t entries [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full     = (count == FULL_CNT);
  assign empty    = (count == '0);
  assign pop_data = entries[rd_ptr];

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + CNT_W'(1);
      end else if (pop && !push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

  // A push into a full queue would overwrite a pixel not yet delivered.
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> !full)
    else $error("queue push while full");

  // A pop from an empty queue would deliver a stale pixel.
  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> !empty)
    else $error("queue pop while empty");

  // The fill count advances by one on a push without a pop.
  a_count_track: assert property (@(posedge clk) disable iff (rst)
    (push && !pop) |=> (count == $past(count) + CNT_W'(1)))
    else $error("queue count did not advance on push");

endmodule

// ----- design/tga_rle_back.sv -----
// Output stage: reorders pixel bytes to RGBA and holds the result transfer.
`timescale 1ns / 1ps

module tga_rle_back (
  input  logic                   clk,
  input  logic                   rst,
  // Queue read side
  input  logic                   q_empty,
  input  tga_rle_pkg::px_entry_t q_data,
  output logic                   q_pop,
  // Result stream
  output logic                   m_tvalid,
  input  logic                   m_tready,
  output logic [39:0]            m_tdata,   // red, green, blue, alpha, repeat_res
  output logic                   m_tlast,   // image_end
  output logic                   m_tuser    // run_clamped
);

  logic [7:0] alpha;

  assign q_pop = !q_empty && (!m_tvalid || m_tready);
  assign alpha = q_data.wide ? q_data.bytes[3] : 8'd0;

  // Valid flag of the output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (q_pop) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  // Result payload, loaded when a pixel leaves the queue.
  always_ff @(posedge clk) begin
    if (q_pop) begin
      m_tdata <= {q_data.count, alpha, q_data.bytes[0], q_data.bytes[1],
                  q_data.bytes[2]};
      m_tlast <= q_data.last;
      m_tuser <= q_data.clamped;
    end
  end

endmodule

// ----- design/tga_rle_pixel_decoder_top.sv -----
// Top level of the TGA run-length pixel decoder.
`timescale 1ns / 1ps

// Decodes the pixel section of a run-length coded TGA image.
// The s_ channel takes one compressed byte per transfer; s_tuser high marks
// the first byte of an image and loads the pixel count from image_pixels.
// The m_ channel gives one result per raw pixel or one per run packet:
// m_tdata holds red, green, blue, alpha and the repeat count, m_tlast marks
// the result that completes the image, m_tuser marks a clamped run.
// The cfg channel writes bytes_per_pixel (index 0) and image_pixels (index 1)
// and is always ready; write it only while the block is idle.
// Throughput is one byte per cycle while s_tready is high: the parser updates
// its packet state for each accepted byte. A result reaches m_ through the
// queue and then the output register: the parser writes the queue when it
// accepts the byte completing the pixel, and the output register loads from
// the queue once it is free or its result is taken.
// Reset clears the decode state and queue; no image is active until a byte
// with s_tuser arrives, and bytes before it are dropped.
// When the receiver stalls, results wait in the output register and the
// queue; s_tready drops only when the queue is full, so input keeps flowing
// until then.
module tga_rle_pixel_decoder_top #(
  parameter int QUEUE_DEPTH = tga_rle_pkg::QUEUE_DEPTH
) (
  input  logic        clk,
  input  logic        rst,
  // Compressed byte stream
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // data_byte
  input  logic        s_tuser,   // frame_start
  // Decoded pixel stream
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata,   // red, green, blue, alpha, repeat_res
  output logic        m_tlast,   // image_end
  output logic        m_tuser,   // run_clamped
  // Configuration writes
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  tga_rle_pkg::px_entry_t push_data;
  tga_rle_pkg::px_entry_t pop_data;
  logic push;
  logic pop;
  logic full;
  logic empty;

  assign cfg_ready = 1'b1;

  tga_rle_front u_front (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .cfg_valid (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .q_full    (full),
    .q_push    (push),
    .q_data    (push_data)
  );

  tga_rle_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .full      (full),
    .pop       (pop),
    .pop_data  (pop_data),
    .empty     (empty)
  );

  tga_rle_back u_back (
    .clk      (clk),
    .rst      (rst),
    .q_empty  (empty),
    .q_data   (pop_data),
    .q_pop    (pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
  );

endmodule

// ----- dv/tga_rle_pixel_checker.sv -----
// Scoreboard that predicts and checks the decoded pixel stream of the TGA RLE decoder.
`timescale 1ns / 1ps

module tga_rle_pixel_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [7:0]  s_tdata,          // data_byte
  input  logic        s_tuser,          // frame_start
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [39:0] m_tdata,          // red, green, blue, alpha, repeat_res
  input  logic        m_tlast,          // image_end
  input  logic        m_tuser,          // run_clamped
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data,
  output int          fail_count,
  output int          pending_results,
  output int          results_checked,
  output int          clamped_runs,
  output int          images_done
);

  localparam int MAX_REPORTS = 40;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
    logic [7:0] repeat_cnt;
    logic       image_end;
    logic       clamped;
  } pixel_result_t;

  // Register copies.
  logic [2:0]  cfg_bpp;
  logic [31:0] cfg_img_pixels;

  // Decoder state as the predictor tracks it.
  bit          hdr_wait;
  bit          in_run;
  int unsigned pkt_left;
  int unsigned byte_idx;
  logic [7:0]  pix_bytes [4];
  logic [31:0] pix_remaining;

  pixel_result_t expected_pixels [$];

  // Advance the decode state by one stream byte and queue the pixel it completes.
  task automatic decode_byte(input logic [7:0] b, input logic start);
    pixel_result_t px;
    int unsigned   psize;
    logic [31:0]   cnt;
    logic          clamp;
    psize = (cfg_bpp == tga_rle_pkg::BPP_WIDE) ? 4 : 3;
    clamp = 1'b0;
    if (start) begin
      pix_remaining = cfg_img_pixels;
      hdr_wait = 1'b1;
      in_run = 1'b0;
      pkt_left = 0;
      byte_idx = 0;
    end
    // No image active: the byte is dropped.
    if (pix_remaining == 0) return;
    if (hdr_wait) begin
      if (b < tga_rle_pkg::HDR_RUN_BASE) begin
        in_run = 1'b0;
        pkt_left = b + 1;
      end else begin
        in_run = 1'b1;
        pkt_left = b - tga_rle_pkg::RUN_OFFSET;
      end
      hdr_wait = 1'b0;
      byte_idx = 0;
      return;
    end
    // A pixel completes once the byte count reaches the size in force now.
    pix_bytes[byte_idx & 3] = b;
    if (byte_idx + 1 < psize) begin
      byte_idx = (byte_idx + 1) & 3;
      return;
    end
    byte_idx = 0;
    if (in_run) begin
      cnt = pkt_left;
      if (cnt > pix_remaining) begin
        cnt = pix_remaining;
        clamp = 1'b1;
      end
      pkt_left = 0;
    end else begin
      cnt = 1;
      pkt_left = (pkt_left - 1) & 8'hFF;
    end
    pix_remaining = pix_remaining - cnt;
    if (pkt_left == 0) hdr_wait = 1'b1;
    px.red        = pix_bytes[2];
    px.green      = pix_bytes[1];
    px.blue       = pix_bytes[0];
    px.alpha      = (psize == 4) ? pix_bytes[3] : 8'd0;
    px.repeat_cnt = cnt[7:0];
    px.image_end  = (pix_remaining == 0);
    px.clamped    = clamp;
    expected_pixels.push_back(px);
  endtask

  function automatic bit field_differs(string name, logic [7:0] want, logic [7:0] got);
    if (want == got) return 1'b0;
    if (fail_count < MAX_REPORTS)
      $display("%0t ns: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want, got);
    return 1'b1;
  endfunction

  // Compare one output transfer with the oldest expected pixel.
  task automatic check_result();
    pixel_result_t want;
    pixel_result_t got;
    bit            bad;
    got.red        = m_tdata[7:0];
    got.green      = m_tdata[15:8];
    got.blue       = m_tdata[23:16];
    got.alpha      = m_tdata[31:24];
    got.repeat_cnt = m_tdata[39:32];
    got.image_end  = m_tlast;
    got.clamped    = m_tuser;
    if (expected_pixels.size() == 0) begin
      if (fail_count < MAX_REPORTS)
        $display("%0t ns: unexpected result, expected none, actual 0x%0h", $time, got);
      fail_count++;
      return;
    end
    want = expected_pixels.pop_front();
    bad = 1'b0;
    bad |= field_differs("red", want.red, got.red);
    bad |= field_differs("green", want.green, got.green);
    bad |= field_differs("blue", want.blue, got.blue);
    bad |= field_differs("alpha", want.alpha, got.alpha);
    bad |= field_differs("repeat", want.repeat_cnt, got.repeat_cnt);
    bad |= field_differs("image_end", want.image_end, got.image_end);
    bad |= field_differs("run_clamped", want.clamped, got.clamped);
    if (bad) fail_count++;
    results_checked++;
    if (want.clamped) clamped_runs++;
    if (want.image_end) images_done++;
  endtask

  // Watch all three channels at each rising edge.
  always @(posedge clk) begin
    if (rst) begin
      cfg_bpp = tga_rle_pkg::BPP_RESET;
      cfg_img_pixels = tga_rle_pkg::IMG_RESET;
      hdr_wait = 1'b1;
      in_run = 1'b0;
      pkt_left = 0;
      byte_idx = 0;
      pix_remaining = '0;
      for (int i = 0; i < 4; i++) pix_bytes[i] = 8'd0;
      expected_pixels.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == tga_rle_pkg::CFG_BYTES_PER_PIXEL) cfg_bpp = cfg_data[2:0];
        else if (cfg_index == tga_rle_pkg::CFG_IMAGE_PIXELS) cfg_img_pixels = cfg_data;
      end
      if (s_tvalid && s_tready) decode_byte(s_tdata, s_tuser);
      if (m_tvalid && m_tready) check_result();
    end
    pending_results = expected_pixels.size();
  end

endmodule

// ----- dv/tb_tga_rle_pixel_decoder_top.sv -----
// Testbench top for the TGA RLE pixel decoder: stimulus, receiver stalls and verdict.
`timescale 1ns / 1ps

module tb_tga_rle_pixel_decoder_top;

  localparam int ITEM_TARGET  = 1750;
  localparam int DRAIN_CYCLES = 8;
  localparam int HOLD_CYCLES  = 120;
  localparam int CYCLE_LIMIT  = 500000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = 8'd0;
  logic        s_tuser = 1'b0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [39:0] m_tdata;
  logic        m_tlast;
  logic        m_tuser;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = 2'd0;
  logic [31:0] cfg_data = 32'd0;

  int fail_count, pending_results, results_checked, clamped_runs, images_done;

  // Sender and receiver bookkeeping.
  int items_sent;
  int bytes_sent;
  int cfg_writes;
  int burst_left;
  bit idle_enabled;
  int hold_requests;
  int hold_seen;
  int hold_left;
  int rx_mode;
  int rx_cycle;
  int cycle_count;

  tga_rle_pixel_decoder_top DUT (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast),
    .m_tuser   (m_tuser),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  tga_rle_pixel_checker pixel_checker (
    .clk             (clk),
    .rst             (rst),
    .s_tvalid        (s_tvalid),
    .s_tready        (s_tready),
    .s_tdata         (s_tdata),
    .s_tuser         (s_tuser),
    .m_tvalid        (m_tvalid),
    .m_tready        (m_tready),
    .m_tdata         (m_tdata),
    .m_tlast         (m_tlast),
    .m_tuser         (m_tuser),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .fail_count      (fail_count),
    .pending_results (pending_results),
    .results_checked (results_checked),
    .clamped_runs    (clamped_runs),
    .images_done     (images_done)
  );

  // 100 MHz clock.
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Run limit.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d results outstanding", cycle_count,
               pending_results);
      $display("tga_rle_pixel_decoder_top test failed");
      $finish;
    end
  end

  // Receiver: long hold-offs on request, otherwise a stall pattern picked at
  // random from four.
  always @(posedge clk) begin
    rx_cycle++;
    if (rx_cycle % 128 == 0) rx_mode = $urandom_range(0, 3);
    if (hold_left > 0) begin
      hold_left--;
      m_tready <= 1'b0;
    end else if (hold_seen != hold_requests) begin
      hold_seen = hold_requests;
      hold_left = HOLD_CYCLES;
      m_tready <= 1'b0;
    end else begin
      case (rx_mode)
        0: begin
          m_tready <= 1'b1;
        end
        1: begin
          m_tready <= ($urandom_range(0, 3) != 0);
        end
        2: begin
          m_tready <= ($urandom_range(0, 2) == 0);
        end
        default: begin
          m_tready <= (rx_cycle % 7 < 5);
        end
      endcase
    end
  end

  // Offer one byte and wait for its transfer; gaps come between random bursts when idling is enabled.
  task automatic send_byte(logic [7:0] b, logic start, bit counted);
    int gap;
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    s_tuser  <= start;
    do @(posedge clk); while (!s_tready);
    bytes_sent++;
    if (counted) items_sent++;
    if (idle_enabled) begin
      if (burst_left == 0) begin
        gap = $urandom_range(1, 8);
        burst_left = $urandom_range(1, 24);
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end else begin
        burst_left--;
      end
    end
  endtask

  // Stop sending, wait for every expected pixel, then let the parser settle.
  task automatic wait_idle();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (pending_results != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_cfg(tga_rle_pkg::cfg_idx_t idx, logic [31:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    cfg_writes++;
    @(posedge clk);
  endtask

  // One image: a start header, then raw and run packets with random pixels.
  task automatic send_frame(logic [31:0] img, int unsigned psize);
    logic [31:0] left;
    int unsigned n;
    int unsigned take;
    int          packets;
    bit          first;
    left = img;
    packets = 0;
    first = 1'b1;
    // Empty image: the start byte and anything after it are dropped.
    if (img == 0) begin
      send_byte(8'($urandom), 1'b1, 1'b1);
      repeat ($urandom_range(0, 2)) send_byte(8'($urandom), 1'b0, 1'b0);
      return;
    end
    while (left != 0 && packets < 24) begin
      // Now and then a packet is cut short; the next frame start restarts over it.
      if (!first && $urandom_range(0, 49) == 0) begin
        send_byte(8'($urandom), 1'b0, 1'b1);
        repeat ($urandom_range(0, 2)) send_byte(8'($urandom), 1'b0, 1'b1);
        return;
      end
      if ($urandom_range(0, 1) == 0) begin
        n = ($urandom_range(0, 5) == 0) ? $urandom_range(1, 128) : $urandom_range(1, 4);
        take = (n > left) ? left : n;
        send_byte(8'(n - 1), first, 1'b1);
        repeat (take * psize) send_byte(8'($urandom), 1'b0, 1'b1);
        // Raw packet running past the image end: its leftover bytes are dropped.
        if (take < n) repeat ($urandom_range(1, 3)) send_byte(8'($urandom), 1'b0, 1'b0);
      end else begin
        n = $urandom_range(1, 128);
        take = (n > left) ? left : n;
        send_byte(8'(n + tga_rle_pkg::RUN_OFFSET), first, 1'b1);
        repeat (psize) send_byte(8'($urandom), 1'b0, 1'b1);
      end
      left = left - take;
      first = 1'b0;
      packets++;
    end
    if (left == 0 && $urandom_range(0, 3) == 0)
      repeat ($urandom_range(1, 3)) send_byte(8'($urandom), 1'b0, 1'b0);
  endtask

  initial begin
    logic [2:0]  cur_bpp;
    logic [31:0] cur_img;
    int          phase;
    int          pick;
    phase = 0;
    idle_enabled = 1'b0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Bytes before any frame start are dropped.
    send_byte(8'h55, 1'b0, 1'b0);
    send_byte(8'hAA, 1'b0, 1'b0);
    // One-pixel image with reset settings, then a byte past its end.
    send_byte(8'h00, 1'b1, 1'b1);
    send_byte(8'h00, 1'b0, 1'b1);
    send_byte(8'hFF, 1'b0, 1'b1);
    send_byte(8'h80, 1'b0, 1'b1);
    send_byte(8'h7F, 1'b0, 1'b0);
    wait_idle();
    // Empty image with 32-bit pixels.
    write_cfg(tga_rle_pkg::CFG_BYTES_PER_PIXEL, 32'(tga_rle_pkg::BPP_WIDE));
    write_cfg(tga_rle_pkg::CFG_IMAGE_PIXELS, 32'd0);
    send_byte(8'hFF, 1'b1, 1'b1);
    send_byte(8'h12, 1'b0, 1'b0);
    wait_idle();
    // Longest run, cut to a three-pixel image.
    write_cfg(tga_rle_pkg::CFG_IMAGE_PIXELS, 32'd3);
    send_byte(8'hFF, 1'b1, 1'b1);
    repeat (4) send_byte(8'hFF, 1'b0, 1'b1);
    wait_idle();
    // Largest image: shortest run, then a raw packet with size changes mid-pixel.
    write_cfg(tga_rle_pkg::CFG_BYTES_PER_PIXEL, 32'(tga_rle_pkg::BPP_RESET));
    write_cfg(tga_rle_pkg::CFG_IMAGE_PIXELS, 32'hFFFF_FFFF);
    send_byte(8'h80, 1'b1, 1'b1);
    send_byte(8'h01, 1'b0, 1'b1);
    send_byte(8'h02, 1'b0, 1'b1);
    send_byte(8'h03, 1'b0, 1'b1);
    send_byte(8'h01, 1'b0, 1'b1);
    send_byte(8'h10, 1'b0, 1'b1);
    send_byte(8'h20, 1'b0, 1'b1);
    wait_idle();
    write_cfg(tga_rle_pkg::CFG_BYTES_PER_PIXEL, 32'(tga_rle_pkg::BPP_WIDE));
    send_byte(8'h30, 1'b0, 1'b1);
    send_byte(8'h40, 1'b0, 1'b1);
    send_byte(8'h50, 1'b0, 1'b1);
    send_byte(8'h60, 1'b0, 1'b1);
    send_byte(8'h70, 1'b0, 1'b1);
    wait_idle();
    write_cfg(tga_rle_pkg::CFG_BYTES_PER_PIXEL, 32'(tga_rle_pkg::BPP_RESET));
    send_byte(8'hC0, 1'b0, 1'b1);
    // A raw packet left open; the first random frame restarts over it.
    send_byte(8'h7F, 1'b0, 1'b1);
    send_byte(8'hEE, 1'b0, 1'b1);

    // Random frames, each with its own settings.
    while (items_sent < ITEM_TARGET) begin
      wait_idle();
      phase++;
      pick = $urandom_range(0, 9);
      if (pick < 4) cur_bpp = tga_rle_pkg::BPP_RESET;
      else if (pick < 8) cur_bpp = tga_rle_pkg::BPP_WIDE;
      else cur_bpp = 3'($urandom);
      pick = $urandom_range(0, 19);
      if (pick == 0) cur_img = 32'd0;
      else if (pick == 1) cur_img = $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'd4294836225;
      else if (pick == 2) cur_img = $urandom;
      else if (pick < 7) cur_img = $urandom_range(1, 4);
      else cur_img = $urandom_range(5, 160);
      // The first frame is long enough to back the block up behind a hold-off.
      if (phase == 1) begin
        cur_bpp = tga_rle_pkg::BPP_RESET;
        cur_img = 32'd200;
      end
      write_cfg(tga_rle_pkg::CFG_BYTES_PER_PIXEL, {29'd0, cur_bpp});
      write_cfg(tga_rle_pkg::CFG_IMAGE_PIXELS, cur_img);
      idle_enabled = (phase != 1) && ($urandom_range(0, 3) != 0);
      if (phase % 5 == 1) hold_requests++;
      if ($urandom_range(0, 9) == 0)
        repeat ($urandom_range(1, 3)) send_byte(8'($urandom), 1'b0, 1'b0);
      send_frame(cur_img, (cur_bpp == tga_rle_pkg::BPP_WIDE) ? 4 : 3);
    end

    wait_idle();
    $display("Sent %0d stream bytes in %0d frames with %0d register writes.",
             bytes_sent, phase, cfg_writes);
    $display("Checked %0d results: %0d clamped runs, %0d completed images, %0d hold-offs.",
             results_checked, clamped_runs, images_done, hold_requests);
    if (fail_count == 0 && pending_results == 0) begin
      $display("tga_rle_pixel_decoder_top test passed");
    end else begin
      $display("tga_rle_pixel_decoder_top test failed");
    end
    $finish;
  end

endmodule
